// ===== rtl/crc8fr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared constants and the byte-wide CRC-8 update of the framed receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

    localparam int unsigned FRAME_LEN   = 6;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAYLOAD_W   = 40;
    localparam logic [7:0]  CRC_POLY    = 8'h8C;
    localparam logic [2:0]  POS_LAST    = 3'd5;

    // Reflected CRC-8, LSB first, eight bit steps unrolled.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++)
        begin
            if ((crc[0] ^ data[0]) == 1'b1)
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crc8_checked_frame_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_core
// Groups received bytes into six-byte frames and reports each frame with a
// CRC-8 good flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / rx_byte carries one serial byte per
//   transfer, frame bytes in arrival order. Every sixth byte closes a frame:
//   bytes 0..3 form value_x (little-endian, signed), byte 4 is value_y and
//   byte 5 is the check byte. Output channel out_valid / out_stall carries
//   one result per frame with crc_ok set when the CRC over all six bytes is
//   zero; bad frames are still reported, with crc_ok low.
//   Throughput: one byte per cycle. Bytes are captured in an input register
//   and the CRC and frame state are updated on the way to the result
//   register, which offers the result after the frame's last byte advances.
//   When out_stall holds the result register full, the next frame-closing
//   byte waits in the input register and in_stall rises; bytes that do not
//   close a frame still pass. Reset clears the frame position, running CRC
//   and both registers' valid flags: the next byte is byte 0 of a frame.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_core
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire         [7:0]  rx_byte,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [31:0] value_x,
    output logic        [7:0]  value_y,
    output logic               crc_ok
);

    // input register
    logic                                 s1_valid_reg;
    logic [crc8fr_pkg::BYTE_W-1:0]        s1_byte_reg;

    // frame state
    logic [crc8fr_pkg::POS_W-1:0]         pos_reg;
    logic [crc8fr_pkg::POS_W-1:0]         pos_next;
    logic [7:0]                           crc_reg;
    logic [7:0]                           crc_next;
    logic [7:0]                           crc_upd;
    logic [crc8fr_pkg::PAYLOAD_W-1:0]     payload_reg;
    logic [crc8fr_pkg::PAYLOAD_W-1:0]     payload_next;

    // result register
    logic                                 out_valid_reg;
    logic [31:0]                          x_reg;
    logic [7:0]                           y_reg;
    logic                                 ok_reg;

    logic                                 is_last;
    logic                                 out_free;
    logic                                 advance;
    logic                                 in_xfer;
    logic                                 out_xfer;

    assign is_last  = (pos_reg >= crc8fr_pkg::POS_LAST);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!is_last || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    assign crc_upd = crc8fr_pkg::crc8_update(crc_reg, s1_byte_reg);

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        payload_next = payload_reg;
        if (advance)
        begin
            if (is_last)
            begin
                pos_next     = '0;
                crc_next     = '0;
                payload_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                crc_next = crc_upd;
                case (pos_reg)
                    3'd0:    payload_next[7:0]   = s1_byte_reg;
                    3'd1:    payload_next[15:8]  = s1_byte_reg;
                    3'd2:    payload_next[23:16] = s1_byte_reg;
                    3'd3:    payload_next[31:24] = s1_byte_reg;
                    3'd4:    payload_next[39:32] = s1_byte_reg;
                    default: payload_next        = payload_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= '0;
            payload_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            payload_reg <= payload_next;
            if (advance && is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance && is_last)
        begin
            x_reg  <= payload_reg[31:0];
            y_reg  <= payload_reg[39:32];
            ok_reg <= (crc_upd == 8'h00);
        end
    end

    assign out_valid = out_valid_reg;
    assign value_x   = $signed(x_reg);
    assign value_y   = y_reg;
    assign crc_ok    = ok_reg;

endmodule
`default_nettype wire

// ===== rtl/crc8fr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fr_checker
// Port-level checks for the framed receiver: result hold under stall and
// result count against completed frames.
// ----------------------------------------------------------------------------
module crc8fr_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [31:0] value_x,
    input wire [7:0]  value_y,
    input wire        crc_ok
);

    logic [2:0] byte_cnt_reg;
    logic [2:0] byte_cnt_next;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;
    logic       frame_done;

    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid && !out_stall;
    assign frame_done = in_xfer && (byte_cnt_reg == crc8fr_pkg::POS_LAST);

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        if (in_xfer)
        begin
            byte_cnt_next = frame_done ? 3'd0 : byte_cnt_reg + 3'd1;
        end
        pending_next = pending_reg + {2'b00, frame_done} - {2'b00, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            pending_reg  <= pending_next;
        end
    end

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn under stall");

    // a stalled result does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(value_x) && $stable(value_y) && $stable(crc_ok))
        else $error("result changed under stall");

    // no result without a completed frame behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result offered with no frame completed");

    // at most one frame in the input register and one in the result register
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many frames outstanding");

endmodule

bind crc8_checked_frame_receiver_core crc8fr_checker u_crc8fr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_x   (value_x),
    .value_y   (value_y),
    .crc_ok    (crc_ok)
);
`default_nettype wire
